// File: hdl/adn_pkg.sv
// Shared types and constants for the axis deadzone normalizer.
// Used by the front end, the divider back end and the top level; depends on nothing.
package adn_pkg;

    // Default fraction width of the Q1.F result
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int RAW_W   = 32;   // raw sample, minimum, maximum
    localparam int FLAT_W  = 31;   // deadzone half width
    localparam int MAG_C_W = 33;   // magnitude of the centered value
    localparam int MAG_D_W = 32;   // magnitude of the divisor

    // Queue between front end and back end
    localparam int MID_DEPTH = 8;
    localparam int MID_CNT_W = $clog2(MID_DEPTH) + 1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_AXIS_MINIMUM  = 2'd0,
        REG_AXIS_MAXIMUM  = 2'd1,
        REG_DEADZONE_FLAT = 2'd2,
        REG_TRIGGER_MODE  = 2'd3
    } adn_reg_idx_t;

    localparam int CFG_IDX_W = $bits(adn_reg_idx_t);

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [RAW_W-1:0]  axis_minimum;
        logic [RAW_W-1:0]  axis_maximum;
        logic [FLAT_W-1:0] deadzone_flat;
        logic              trigger_mode;
    } adn_cfg_t;

    // Classified request handed from the front end to the divider
    typedef struct packed {
        logic [MAG_C_W-1:0] mag_c;   // |centered value|
        logic [MAG_D_W-1:0] mag_d;   // |divisor|
        logic               neg;     // quotient is negative
        logic               inv;     // divisor is zero
    } adn_work_t;

    localparam int WORK_W = $bits(adn_work_t);

endpackage

// File: hdl/adn_fifo.sv
// Small first-word-fall-through queue built from a register array.
// Generic; depends on nothing. DEPTH must be a power of two.
module adn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH) + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

// File: hdl/adn_front.sv
// Front end: accepts raw samples, clamps, applies the deadzone, centers,
// and classifies sign and divisor. Depends on adn_pkg.
module adn_front
    import adn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  adn_cfg_t             cfg,
    input  logic                 push,
    input  logic [RAW_W-1:0]     raw_sample,
    output logic                 full,
    input  logic [MID_CNT_W-1:0] mid_count,
    output logic                 work_valid,
    output adn_work_t            work
);

    logic accept;

    logic signed [RAW_W-1:0] raw_s, min_s, max_s;
    logic signed [RAW_W-1:0] clamp_v;
    logic signed [RAW_W:0]   v_ext, flat_s;
    logic signed [RAW_W:0]   span, span_adj, half_full;

    logic signed [RAW_W-1:0] half_reg, half_next;

    logic                    s1_vld_reg;
    logic signed [RAW_W-1:0] s1_v_reg, s1_v_next;

    logic                    s2_vld_reg;
    logic signed [RAW_W+1:0] s2_c_reg, s2_c_next;
    logic signed [RAW_W:0]   s2_d_reg, s2_d_next;

    logic                    s3_vld_reg;
    adn_work_t               s3_reg, s3_next;
    logic signed [RAW_W+1:0] c_abs;
    logic signed [RAW_W:0]   d_abs;

    logic [MID_CNT_W-1:0]    inflight;

    // Hold off when the queue cannot take everything already in flight
    assign inflight = MID_CNT_W'(s1_vld_reg) + MID_CNT_W'(s2_vld_reg)
                    + MID_CNT_W'(s3_vld_reg);
    assign full     = (mid_count + inflight) >= MID_CNT_W'(MID_DEPTH);
    assign accept   = push && !full;

    assign raw_s = $signed(raw_sample);
    assign min_s = $signed(cfg.axis_minimum);
    assign max_s = $signed(cfg.axis_maximum);

    // Derive the half span from the limits, truncated toward zero
    always_comb
    begin
        span      = {max_s[RAW_W-1], max_s} - {min_s[RAW_W-1], min_s};
        span_adj  = span + $signed({{RAW_W{1'b0}}, span[RAW_W]});
        half_full = span_adj >>> 1;
        half_next = half_full[RAW_W-1:0];
    end

    // Clamp against maximum first, then minimum; zero inside the deadzone
    always_comb
    begin
        if (raw_s > max_s)
        begin
            clamp_v = max_s;
        end
        else if (raw_s < min_s)
        begin
            clamp_v = min_s;
        end
        else
        begin
            clamp_v = raw_s;
        end
        v_ext  = {clamp_v[RAW_W-1], clamp_v};
        flat_s = $signed({2'b00, cfg.deadzone_flat});
        if ((v_ext > -flat_s) && (v_ext < flat_s))
        begin
            s1_v_next = '0;
        end
        else
        begin
            s1_v_next = clamp_v;
        end
    end

    // Center on the half span and pick the divisor by sign
    always_comb
    begin
        s2_c_next = {{2{s1_v_reg[RAW_W-1]}}, s1_v_reg}
                  - {{2{max_s[RAW_W-1]}}, max_s}
                  + {{2{half_reg[RAW_W-1]}}, half_reg};
        if (s2_c_next[RAW_W+1])
        begin
            s2_d_next = {half_reg[RAW_W-1], half_reg} + (RAW_W+1)'(1);
        end
        else
        begin
            s2_d_next = {half_reg[RAW_W-1], half_reg};
        end
    end

    // Split into magnitudes and a result sign
    always_comb
    begin
        c_abs         = s2_c_reg[RAW_W+1] ? -s2_c_reg : s2_c_reg;
        d_abs         = s2_d_reg[RAW_W] ? -s2_d_reg : s2_d_reg;
        s3_next.mag_c = c_abs[MAG_C_W-1:0];
        s3_next.mag_d = d_abs[MAG_D_W-1:0];
        s3_next.neg   = s2_c_reg[RAW_W+1] ^ s2_d_reg[RAW_W];
        s3_next.inv   = (s2_d_reg == '0);
    end

    // Advance the stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        half_reg <= half_next;
        s1_v_reg <= s1_v_next;
        s2_c_reg <= s2_c_next;
        s2_d_reg <= s2_d_next;
        s3_reg   <= s3_next;
    end

    assign work_valid = s3_vld_reg;
    assign work       = s3_reg;

endmodule

// File: hdl/adn_back.sv
// Back end: restoring divider, one quotient bit per stage, then saturation,
// sign and trigger mapping into the result queue. Depends on adn_pkg, adn_fifo.
module adn_back
    import adn_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       trigger_mode,
    input  logic                       mid_valid,
    output logic                       mid_pop,
    input  adn_work_t                  work,
    input  logic                       pop,
    output logic                       empty,
    output logic [FRACTION_BITS+1:0]   normalized_value,
    output logic                       range_invalid
);

    localparam int OUT_W     = FRACTION_BITS + 2;
    localparam int QUO_W     = FRACTION_BITS + 1;
    localparam int STAGES    = FRACTION_BITS + 1;
    localparam int OUT_DEPTH = 1 << $clog2(FRACTION_BITS + 5);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH) + 1;
    localparam int REM_W     = MAG_C_W;

    localparam logic [QUO_W-1:0] ONE_Q   = QUO_W'(1) << FRACTION_BITS;
    localparam logic [OUT_W:0]   ONE_EXT = (OUT_W+1)'(1) << FRACTION_BITS;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [QUO_W-1:0]   quo;
        logic [MAG_D_W-1:0] dvs;
        logic               neg;
        logic               inv;
        logic               sat;
    } div_t;

    logic                 issue;
    logic [OUT_CNT_W-1:0] out_count;
    logic [OUT_CNT_W:0]   committed;

    logic [OUT_CNT_W-1:0] inflight_reg, inflight_next;

    logic                 p0_vld_reg;
    div_t                 p0_reg, p0_next;

    logic                 div_vld_reg [STAGES];
    div_t                 div_reg     [STAGES];
    div_t                 div_in      [STAGES];
    div_t                 div_next    [STAGES];

    logic                 fin_vld_reg;
    logic [OUT_W-1:0]     fin_value_reg, fin_value_next;
    logic                 fin_inv_reg;

    logic [QUO_W-1:0]     mag;
    logic signed [OUT_W-1:0] val;
    logic [OUT_W:0]       tsum;

    logic                 out_pop;
    logic [OUT_W:0]       out_data;

    // Issue only when the result queue has room for all requests in flight
    assign out_pop   = pop && !empty;
    assign committed = (OUT_CNT_W+1)'(out_count) + (OUT_CNT_W+1)'(inflight_reg);
    assign issue     = mid_valid && (committed < (OUT_CNT_W+1)'(OUT_DEPTH));
    assign mid_pop   = issue;

    // Track requests between issue and the result queue
    always_comb
    begin
        inflight_next = inflight_reg;
        if (issue && !fin_vld_reg)
        begin
            inflight_next = inflight_reg + OUT_CNT_W'(1);
        end
        else if (fin_vld_reg && !issue)
        begin
            inflight_next = inflight_reg - OUT_CNT_W'(1);
        end
    end

    // Latch the request and flag quotients that must saturate
    always_comb
    begin
        p0_next.rem = work.mag_c;
        p0_next.quo = '0;
        p0_next.dvs = work.mag_d;
        p0_next.neg = work.neg;
        p0_next.inv = work.inv;
        p0_next.sat = work.mag_c >= {work.mag_d, 1'b0};
    end

    // One restoring step per stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_div
        logic [REM_W-1:0] trial;
        logic             qbit;

        if (k == 0)
        begin : g_first
            assign div_in[k] = p0_reg;
            assign trial     = div_in[k].rem;
        end
        else
        begin : g_rest
            assign div_in[k] = div_reg[k-1];
            assign trial     = {div_in[k].rem[REM_W-2:0], 1'b0};
        end

        always_comb
        begin
            qbit        = trial >= {1'b0, div_in[k].dvs};
            div_next[k] = div_in[k];
            div_next[k].rem = qbit ? trial - {1'b0, div_in[k].dvs} : trial;
            div_next[k].quo = {div_in[k].quo[QUO_W-2:0], qbit};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[k] <= 1'b0;
            end
            else
            begin
                div_vld_reg[k] <= (k == 0) ? p0_vld_reg : div_vld_reg[k-1 < 0 ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[k] <= div_next[k];
        end
    end

    // Saturate, apply sign, map to the trigger range, force zero on a bad range
    always_comb
    begin
        if (div_reg[STAGES-1].sat || (div_reg[STAGES-1].quo > ONE_Q))
        begin
            mag = ONE_Q;
        end
        else
        begin
            mag = div_reg[STAGES-1].quo;
        end
        val  = div_reg[STAGES-1].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        tsum = {val[OUT_W-1], val} + ONE_EXT;
        if (div_reg[STAGES-1].inv)
        begin
            fin_value_next = '0;
        end
        else if (trigger_mode)
        begin
            fin_value_next = tsum[OUT_W:1];
        end
        else
        begin
            fin_value_next = val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            p0_vld_reg   <= 1'b0;
            fin_vld_reg  <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            p0_vld_reg   <= issue;
            fin_vld_reg  <= div_vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg        <= p0_next;
        fin_value_reg <= fin_value_next;
        fin_inv_reg   <= div_reg[STAGES-1].inv;
    end

    // Result queue
    adn_fifo #(
        .WIDTH (OUT_W + 1),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fin_vld_reg),
        .push_data ({fin_value_reg, fin_inv_reg}),
        .pop       (out_pop),
        .pop_data  (out_data),
        .count     (out_count)
    );

    assign empty            = (out_count == '0);
    assign normalized_value = out_data[OUT_W:1];
    assign range_invalid    = out_data[0];

endmodule

// File: hdl/axis_deadzone_normalizer.sv
// Axis deadzone normalizer top level: configuration registers and the queue
// between front end and divider back end. Depends on adn_pkg, adn_fifo,
// adn_front, adn_back.
//
// Takes one raw signed axis sample per cycle and returns one signed
// Q1.FRACTION_BITS position per sample, in order. Both sides behave as
// queues: push a request while full is low, pop a result while empty is low.
// A sample passes from push through the three-stage front end, the queue
// hop, and the divider, which resolves one quotient bit per pipeline stage,
// before its result is visible.
// Throughput is one sample per cycle as long as results are popped; the
// result queue is sized so that the divider never stalls mid-flight.
// Write configuration only while no sample is in flight. A zero divisor
// gives a value of zero with range_invalid set.
module axis_deadzone_normalizer
    import adn_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [RAW_W-1:0]         cfg_data,
    input  logic                     push,
    output logic                     full,
    input  logic [RAW_W-1:0]         raw_sample,
    output logic                     empty,
    input  logic                     pop,
    output logic [FRACTION_BITS+1:0] normalized_value,
    output logic                     range_invalid
);

    adn_cfg_t             cfg_reg, cfg_next;

    logic                 work_valid;
    adn_work_t            work_front;
    logic [WORK_W-1:0]    mid_data;
    logic [MID_CNT_W-1:0] mid_count;
    logic                 mid_pop;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (adn_reg_idx_t'(cfg_index))
                REG_AXIS_MINIMUM:  cfg_next.axis_minimum  = cfg_data;
                REG_AXIS_MAXIMUM:  cfg_next.axis_maximum  = cfg_data;
                REG_DEADZONE_FLAT: cfg_next.deadzone_flat = cfg_data[FLAT_W-1:0];
                REG_TRIGGER_MODE:  cfg_next.trigger_mode  = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_minimum  <= '0;
            cfg_reg.axis_maximum  <= RAW_W'(255);
            cfg_reg.deadzone_flat <= '0;
            cfg_reg.trigger_mode  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    adn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .raw_sample (raw_sample),
        .full       (full),
        .mid_count  (mid_count),
        .work_valid (work_valid),
        .work       (work_front)
    );

    // Queue between front end and divider
    adn_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (work_valid),
        .push_data (work_front),
        .pop       (mid_pop),
        .pop_data  (mid_data),
        .count     (mid_count)
    );

    adn_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .trigger_mode     (cfg_reg.trigger_mode),
        .mid_valid        (mid_count != '0),
        .mid_pop          (mid_pop),
        .work             (adn_work_t'(mid_data)),
        .pop              (pop),
        .empty            (empty),
        .normalized_value (normalized_value),
        .range_invalid    (range_invalid)
    );

endmodule
